@@ sv/sc1kt_pkg.sv @@
// ----------------------------------------------------------------------------
// sc1kt_pkg
// Types, constants and lookup functions for the scan code set 1 translator.
// ----------------------------------------------------------------------------
`default_nettype none

package sc1kt_pkg;

    localparam int SCAN_W    = 8;
    localparam int CODE_W    = 7;
    localparam int CHAR_W    = 8;
    localparam int KEY_COUNT = 1 << CODE_W;
    localparam int TBL_LEN   = 64;

    typedef logic [SCAN_W-1:0] scan_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CHAR_W-1:0] char_t;

    localparam scan_t PREFIX_BYTE = 8'hE0;
    localparam code_t CODE_LSHIFT = 7'h2A;
    localparam code_t CODE_RSHIFT = 7'h36;
    localparam code_t CODE_CTRL   = 7'h1D;
    localparam code_t CODE_ALT    = 7'h38;

    localparam code_t CODE_UP     = 7'h48;
    localparam code_t CODE_DOWN   = 7'h50;
    localparam code_t CODE_LEFT   = 7'h4B;
    localparam code_t CODE_RIGHT  = 7'h4D;
    localparam code_t CODE_HOME   = 7'h47;
    localparam code_t CODE_END    = 7'h4F;
    localparam code_t CODE_PGUP   = 7'h49;
    localparam code_t CODE_PGDN   = 7'h51;
    localparam code_t CODE_INS    = 7'h52;
    localparam code_t CODE_DEL    = 7'h53;

    localparam char_t PLAIN_TAB [TBL_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam char_t SHIFT_TAB [TBL_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic char_t ext_char(input code_t code);
        char_t c;
        unique case (code)
            CODE_UP:    c = 8'd128;
            CODE_DOWN:  c = 8'd129;
            CODE_LEFT:  c = 8'd130;
            CODE_RIGHT: c = 8'd131;
            CODE_HOME:  c = 8'd132;
            CODE_END:   c = 8'd133;
            CODE_PGUP:  c = 8'd134;
            CODE_PGDN:  c = 8'd135;
            CODE_INS:   c = 8'd136;
            CODE_DEL:   c = 8'd137;
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic char_t plain_char(input code_t code, input logic shift,
                                         input logic ctrl);
        char_t c;
        c = '0;
        if (code[CODE_W-1] == 1'b0)
            c = shift ? SHIFT_TAB[code[CODE_W-2:0]] : PLAIN_TAB[code[CODE_W-2:0]];
        if (ctrl && c >= 8'h61 && c <= 8'h7A)
            c = c - 8'h60;
        if (ctrl && c >= 8'h41 && c <= 8'h5A)
            c = c - 8'h40;
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/sc1kt_scan_if.sv @@
// ----------------------------------------------------------------------------
// sc1kt_scan_if
// Request channel carrying one raw scan code byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc1kt_scan_if;
    import sc1kt_pkg::*;

    logic  valid;
    logic  ready;
    scan_t scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

`default_nettype wire

@@ sv/sc1kt_key_if.sv @@
// ----------------------------------------------------------------------------
// sc1kt_key_if
// Request channel carrying one translated key event.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc1kt_key_if;
    import sc1kt_pkg::*;

    logic  valid;
    logic  ready;
    code_t key_scan;
    logic  pressed;
    char_t key_char;
    logic  mod_shift;
    logic  mod_ctrl;
    logic  mod_alt;

    modport source (output valid, output key_scan, output pressed, output key_char,
                    output mod_shift, output mod_ctrl, output mod_alt, input ready);
    modport sink   (input valid, input key_scan, input pressed, input key_char,
                    input mod_shift, input mod_ctrl, input mod_alt, output ready);
endinterface

`default_nettype wire

@@ sv/scancode_set1_key_event_translator_top.sv @@
// ----------------------------------------------------------------------------
// scancode_set1_key_event_translator_top
// Scan code set 1 byte stream to key events with modifier tracking.
// ----------------------------------------------------------------------------
// One scan byte is taken per cycle after the reset sweep, unless back-pressure
// on key_ch stalls the lookup stage. Each byte yields at most one registered
// key event. The key-down map sits in a 128 x 1 synchronous RAM: the byte's
// code is looked up at acceptance and the bit is written back when the byte
// leaves the lookup stage, with the last write forwarded to a back-to-back
// lookup of the same key. After reset the RAM is swept to zero, during which
// scan_ch.ready stays low. A prefix byte or a repeated make gives no event.
`default_nettype none

module scancode_set1_key_event_translator_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sc1kt_scan_if.sink scan_ch,
    sc1kt_key_if.source key_ch
);
    import sc1kt_pkg::*;

    logic keymap_mem [KEY_COUNT];

    logic  clearing_reg;
    code_t clr_cnt_reg;

    logic  s1_valid_reg;
    scan_t s1_byte_reg;
    logic  rd_data_reg;

    logic  fwd_valid_reg;
    code_t fwd_addr_reg;
    logic  fwd_data_reg;

    logic  lshift_reg, lshift_next;
    logic  rshift_reg, rshift_next;
    logic  ctrl_reg, ctrl_next;
    logic  alt_reg, alt_next;
    logic  prefix_reg, prefix_next;

    logic  out_valid_reg;
    code_t out_scan_reg;
    logic  out_pressed_reg;
    char_t out_char_reg;
    logic  out_shift_reg;
    logic  out_ctrl_reg;
    logic  out_alt_reg;

    logic  in_fire;
    logic  s1_adv;
    code_t s1_code;
    logic  s1_make;
    logic  s1_prefix;
    logic  held;
    logic  emit;
    logic  wr_en;
    code_t wr_addr;
    logic  wr_data;
    logic  shift_now;
    char_t kc;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || key_ch.ready);
    assign scan_ch.ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign in_fire  = scan_ch.valid && scan_ch.ready;

    assign s1_code   = s1_byte_reg[CODE_W-1:0];
    assign s1_make   = !s1_byte_reg[SCAN_W-1];
    assign s1_prefix = (s1_byte_reg == PREFIX_BYTE);
    assign held      = (fwd_valid_reg && fwd_addr_reg == s1_code) ? fwd_data_reg
                                                                  : rd_data_reg;
    assign emit      = s1_adv && !s1_prefix && !(s1_make && held);

    always_comb
    begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        ctrl_next   = ctrl_reg;
        alt_next    = alt_reg;
        prefix_next = prefix_reg;
        if (s1_adv)
        begin
            if (s1_prefix)
                prefix_next = 1'b1;
            else
            begin
                prefix_next = 1'b0;
                if (emit)
                begin
                    if (s1_code == CODE_LSHIFT) lshift_next = s1_make;
                    if (s1_code == CODE_RSHIFT) rshift_next = s1_make;
                    if (s1_code == CODE_CTRL)   ctrl_next   = s1_make;
                    if (s1_code == CODE_ALT)    alt_next    = s1_make;
                end
            end
        end
        shift_now = lshift_next | rshift_next;
        kc = prefix_reg ? ext_char(s1_code) : plain_char(s1_code, shift_now, ctrl_next);
    end

    // RAM write port: clear sweep or key map update
    always_comb
    begin
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = 1'b0;
        end
        else
        begin
            wr_en   = emit;
            wr_addr = s1_code;
            wr_data = s1_make;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            keymap_mem[wr_addr] <= wr_data;
        if (in_fire)
            rd_data_reg <= keymap_mem[scan_ch.scan_byte[CODE_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            lshift_reg    <= 1'b0;
            rshift_reg    <= 1'b0;
            ctrl_reg      <= 1'b0;
            alt_reg       <= 1'b0;
            prefix_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == code_t'(KEY_COUNT - 1))
                    clearing_reg <= 1'b0;
            end
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (!clearing_reg && emit)
                fwd_valid_reg <= 1'b1;
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            ctrl_reg   <= ctrl_next;
            alt_reg    <= alt_next;
            prefix_reg <= prefix_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (key_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_byte_reg <= scan_ch.scan_byte;
        if (emit)
        begin
            fwd_addr_reg    <= s1_code;
            fwd_data_reg    <= s1_make;
            out_scan_reg    <= s1_code;
            out_pressed_reg <= s1_make;
            out_char_reg    <= kc;
            out_shift_reg   <= shift_now;
            out_ctrl_reg    <= ctrl_next;
            out_alt_reg     <= alt_next;
        end
    end

    assign key_ch.valid     = out_valid_reg;
    assign key_ch.key_scan  = out_scan_reg;
    assign key_ch.pressed   = out_pressed_reg;
    assign key_ch.key_char  = out_char_reg;
    assign key_ch.mod_shift = out_shift_reg;
    assign key_ch.mod_ctrl  = out_ctrl_reg;
    assign key_ch.mod_alt   = out_alt_reg;

endmodule

`default_nettype wire

@@ tb/scancode_set1_key_event_translator_top_test.sv @@
// ----------------------------------------------------------------------------
// scancode_set1_key_event_translator_top_test
// Drives scan code set 1 bytes through the translator and checks every key event.
// ----------------------------------------------------------------------------
// A short directed sequence covers the special cases: prefix, double prefix,
// auto-repeat, prefix cleared by a repeat, navigation keys, modifiers and the
// code extremes. Random keystroke sequences follow, mixed with some noise
// bytes. A local predictor keeps its own key-down map and modifier state.
// Every key event is compared field by field, in order, with the events
// predicted at request time. Both sides idle at random. The receiver holds
// off for long stretches, and the sender pauses once until every predicted
// event has arrived.
// ----------------------------------------------------------------------------
module scancode_set1_key_event_translator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sc1kt_pkg::*;

    localparam int    IDLE_LIMIT   = 2000;
    localparam int    TARGET_BYTES = 400;
    localparam int    HOLD_CYCLES  = 120;
    localparam scan_t BREAK_BIT    = 8'h80;
    localparam char_t NAV_BASE     = 8'd128;
    localparam code_t KEY_A        = 7'h1E;
    localparam code_t KEY_Q        = 7'h10;
    localparam code_t KEY_C        = 7'h2E;

    localparam code_t NAV_CODES [10] = '{
        CODE_UP, CODE_DOWN, CODE_LEFT, CODE_RIGHT, CODE_HOME,
        CODE_END, CODE_PGUP, CODE_PGDN, CODE_INS, CODE_DEL
    };

    localparam char_t UNSHIFTED_CHARS [64] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam char_t SHIFTED_CHARS [64] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        code_t key_scan;
        logic  pressed;
        char_t key_char;
        logic  mod_shift;
        logic  mod_ctrl;
        logic  mod_alt;
    } key_event_t;

    typedef struct {
        bit    pause;
        scan_t value;
    } scan_slot_t;

    logic clk;
    logic rst_n;

    sc1kt_scan_if scan_ch();
    sc1kt_key_if  key_ch();

    scancode_set1_key_event_translator_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_ch (scan_ch),
        .key_ch  (key_ch)
    );

    // predictor state
    bit keys_down [128];
    bit lshift_down;
    bit rshift_down;
    bit ctrl_down;
    bit alt_down;
    bit prefix_seen;

    key_event_t expected_events [$];
    scan_slot_t pending_bytes [$];

    bit gen_down [128];

    int scan_requests;
    int events_checked;
    int prefixes_seen;
    int repeats_dropped;
    int mismatches;
    int idle_cycles;
    bit scan_taken;
    bit calm;

    int send_gap;
    int stall_left;
    int hold_left;
    bit first_hold_done;
    bit second_hold_done;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit predict_key_event(input scan_t b, output key_event_t ev);
        code_t code;
        logic  make;
        logic  shift;
        char_t c;
        ev = '0;
        if (b == PREFIX_BYTE) begin
            prefix_seen = 1'b1;
            prefixes_seen++;
            return 1'b0;
        end
        code = b[6:0];
        make = ~b[7];
        if (make && keys_down[code]) begin
            prefix_seen = 1'b0;
            repeats_dropped++;
            return 1'b0;
        end
        keys_down[code] = make;
        if (code == CODE_LSHIFT)
            lshift_down = make;
        if (code == CODE_RSHIFT)
            rshift_down = make;
        if (code == CODE_CTRL)
            ctrl_down = make;
        if (code == CODE_ALT)
            alt_down = make;
        shift = lshift_down | rshift_down;
        c = '0;
        if (prefix_seen) begin
            for (int i = 0; i < 10; i++)
                if (NAV_CODES[i] == code)
                    c = NAV_BASE + char_t'(i);
        end else begin
            if (!code[6])
                c = shift ? SHIFTED_CHARS[code[5:0]] : UNSHIFTED_CHARS[code[5:0]];
            if (ctrl_down && c >= "a" && c <= "z")
                c = c - "a" + 8'd1;
            else if (ctrl_down && c >= "A" && c <= "Z")
                c = c - "A" + 8'd1;
        end
        ev = '{code, make, c, shift, ctrl_down, alt_down};
        prefix_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_key_event(input key_event_t want);
        if (key_ch.key_scan !== want.key_scan)
            note_mismatch($sformatf("key_scan got %h, want %h", key_ch.key_scan, want.key_scan));
        if (key_ch.pressed !== want.pressed)
            note_mismatch($sformatf("pressed got %b, want %b (key %h)",
                                    key_ch.pressed, want.pressed, want.key_scan));
        if (key_ch.key_char !== want.key_char)
            note_mismatch($sformatf("key_char got %h, want %h (key %h)",
                                    key_ch.key_char, want.key_char, want.key_scan));
        if (key_ch.mod_shift !== want.mod_shift)
            note_mismatch($sformatf("mod_shift got %b, want %b (key %h)",
                                    key_ch.mod_shift, want.mod_shift, want.key_scan));
        if (key_ch.mod_ctrl !== want.mod_ctrl)
            note_mismatch($sformatf("mod_ctrl got %b, want %b (key %h)",
                                    key_ch.mod_ctrl, want.mod_ctrl, want.key_scan));
        if (key_ch.mod_alt !== want.mod_alt)
            note_mismatch($sformatf("mod_alt got %b, want %b (key %h)",
                                    key_ch.mod_alt, want.mod_alt, want.key_scan));
    endtask

    // queues one byte; gen_down follows which keys the stream leaves held
    task automatic queue_byte(input scan_t b);
        pending_bytes.push_back('{1'b0, b});
        if (b == PREFIX_BYTE)
            return;
        if (!b[7] && gen_down[b[6:0]])
            return;
        gen_down[b[6:0]] = ~b[7];
    endtask

    task automatic queue_key(input code_t code, input bit brk);
        queue_byte({brk, code});
    endtask

    // monitor: prediction on accepted requests, checking on accepted events
    always @(posedge clk) begin
        key_event_t ev;
        bit         scan_fire;
        bit         key_fire;
        scan_fire = rst_n && scan_ch.valid === 1'b1 && scan_ch.ready === 1'b1;
        key_fire  = rst_n && key_ch.valid === 1'b1 && key_ch.ready === 1'b1;
        if (scan_fire) begin
            scan_requests++;
            if (predict_key_event(scan_ch.scan_byte, ev))
                expected_events.push_back(ev);
        end
        scan_taken = scan_fire;
        if (key_fire) begin
            if (expected_events.size() == 0) begin
                note_mismatch($sformatf("unexpected key event, key %h", key_ch.key_scan));
            end else begin
                ev = expected_events.pop_front();
                check_key_event(ev);
                events_checked++;
            end
        end
        calm = scan_requests >= 150 && scan_requests < 210;
        if (scan_fire || key_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no request accepted for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // sender
    always @(negedge clk) begin
        bit         next_valid;
        scan_t      next_byte;
        scan_slot_t slot;
        next_valid = scan_ch.valid;
        next_byte  = scan_ch.scan_byte;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else if (!(scan_ch.valid && !scan_taken)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_bytes.size() != 0) begin
                if (pending_bytes[0].pause) begin
                    if (expected_events.size() == 0)
                        void'(pending_bytes.pop_front());
                end else begin
                    slot       = pending_bytes.pop_front();
                    next_valid = 1'b1;
                    next_byte  = slot.value;
                    send_gap   = calm ? 0 : pick_gap();
                end
            end
        end
        scan_ch.valid     <= next_valid;
        scan_ch.scan_byte <= next_byte;
    end

    // receiver, with two long hold-offs while the sender keeps going
    always @(negedge clk) begin
        bit rdy;
        if (!first_hold_done && scan_requests >= 60) begin
            first_hold_done = 1'b1;
            hold_left       = HOLD_CYCLES;
        end
        if (!second_hold_done && scan_requests >= 300) begin
            second_hold_done = 1'b1;
            hold_left        = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (!calm)
                stall_left = pick_gap();
        end
        key_ch.ready <= rdy;
    end

    initial begin
        int    r;
        code_t code;
        bit    ext;
        bit    brk;
        bit    paused;

        rst_n  = 1'b0;
        paused = 1'b0;

        // repeat, shifted letter, control letter
        queue_key(KEY_A, 1'b0);
        queue_key(KEY_A, 1'b0);
        queue_key(KEY_A, 1'b1);
        queue_key(CODE_RSHIFT, 1'b0);
        queue_key(KEY_Q, 1'b0);
        queue_key(KEY_Q, 1'b1);
        queue_key(CODE_RSHIFT, 1'b1);
        queue_key(CODE_CTRL, 1'b0);
        queue_key(KEY_C, 1'b0);
        queue_key(KEY_C, 1'b1);
        queue_key(CODE_CTRL, 1'b1);
        // navigation make and break, double prefix
        queue_byte(PREFIX_BYTE);
        queue_key(CODE_UP, 1'b0);
        queue_byte(PREFIX_BYTE);
        queue_key(CODE_UP, 1'b1);
        queue_byte(PREFIX_BYTE);
        queue_byte(PREFIX_BYTE);
        queue_key(CODE_DEL, 1'b0);
        // prefix cleared by a dropped repeat, under alt
        queue_key(CODE_ALT, 1'b0);
        queue_key(KEY_A, 1'b0);
        queue_byte(PREFIX_BYTE);
        queue_key(KEY_A, 1'b0);
        queue_key(KEY_A, 1'b1);
        queue_key(CODE_ALT, 1'b1);
        // code extremes
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(8'hFF);
        queue_byte(BREAK_BIT);

        while (pending_bytes.size() < TARGET_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                queue_byte(scan_t'($urandom_range(0, 255)));
            end else begin
                r    = $urandom_range(0, 99);
                ext  = $urandom_range(0, 3) == 0;
                code = code_t'($urandom_range(0, 63));
                if (r < 20) begin
                    case ($urandom_range(0, 3))
                        0: code = CODE_LSHIFT;
                        1: code = CODE_RSHIFT;
                        2: code = CODE_CTRL;
                        default: code = CODE_ALT;
                    endcase
                end else if (r < 35) begin
                    code = NAV_CODES[$urandom_range(0, 9)];
                    ext  = $urandom_range(0, 9) < 7;
                end else if (r >= 85) begin
                    code = code_t'($urandom_range(0, 127));
                end
                if (gen_down[code])
                    brk = $urandom_range(0, 9) < 7;
                else
                    brk = $urandom_range(0, 99) < 15;
                if (ext)
                    queue_byte(PREFIX_BYTE);
                if (ext && $urandom_range(0, 19) == 0)
                    queue_byte(PREFIX_BYTE);
                queue_key(code, brk);
            end
            if (!paused && pending_bytes.size() >= 200) begin
                paused = 1'b1;
                pending_bytes.push_back('{1'b1, '0});
            end
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || scan_ch.valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d scan bytes (%0d prefixes, %0d repeats dropped),",
                 scan_requests, prefixes_seen, repeats_dropped);
        $display("checked %0d key events across shift, ctrl, alt and navigation keys.",
                 events_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
sv/sc1kt_pkg.sv
sv/sc1kt_scan_if.sv
sv/sc1kt_key_if.sv
sv/scancode_set1_key_event_translator_top.sv
tb/scancode_set1_key_event_translator_top_test.sv
